// File: rtl/core/xxe_pkg.sv
// shared types, constants and character helpers of the xxencode stream encoder
package xxe_pkg;

	// line geometry
	localparam int LINE_BYTES = 45;
	localparam int FILL_W     = $clog2(LINE_BYTES + 1);
	localparam int ADDR_W     = $clog2(LINE_BYTES);
	localparam int BYTES_PER_GRP = 3;

	// word field widths
	localparam int BYTE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int COUNT_W = 3;

	// fixed characters
	localparam logic [CHAR_W-1:0] CH_NL   = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_PLUS = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_E    = 7'h65;
	localparam logic [CHAR_W-1:0] CH_N    = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_D    = 7'h64;

	// output group select
	typedef enum logic [2:0] {
		SEL_HEAD = 3'd0,
		SEL_LEN  = 3'd1,
		SEL_DATA = 3'd2,
		SEL_NL   = 3'd3,
		SEL_PLUS = 3'd4,
		SEL_END  = 3'd5
	} grp_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       ld_out;
		grp_sel_t   sel;
		logic [1:0] head_idx;
		logic       last;
		logic       base_clr;
		logic       base_inc;
		logic       fetch_en;
		logic [1:0] fetch_k;
	} xxe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic line_go;
		logic out_free;
		logic more_grp;
	} xxe_sts_t;

	// six-bit value to xxencode alphabet character
	function automatic logic [CHAR_W-1:0] code_of(input logic [5:0] v);
		logic [CHAR_W-1:0] w;
		begin
			w = {1'b0, v};
			if (v == 6'd0) begin
				code_of = CH_PLUS;
			end else if (v == 6'd1) begin
				code_of = 7'h2D;
			end else if (v < 6'd12) begin
				code_of = w + 7'd46;
			end else if (v < 6'd38) begin
				code_of = w + 7'd53;
			end else begin
				code_of = w + 7'd59;
			end
		end
	endfunction

	// header text "begin 644 -\n" in three four-character groups
	function automatic logic [4*CHAR_W-1:0] head_grp(input logic [1:0] idx);
		begin
			case (idx)
				2'd0:    head_grp = {7'h62, 7'h65, 7'h67, 7'h69};
				2'd1:    head_grp = {7'h6E, 7'h20, 7'h36, 7'h34};
				default: head_grp = {7'h34, 7'h20, 7'h2D, CH_NL};
			endcase
		end
	endfunction

endpackage

// File: rtl/core/xxe_if.sv
// stream interfaces: raw byte words in, character group words out
interface xxe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, data_byte, end_of_data, input ready);
	modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface xxe_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_0;
	logic [6:0] char_1;
	logic [6:0] char_2;
	logic [6:0] char_3;
	logic [2:0] char_count;
	logic       last_of_run;
	logic       end_of_output;

	modport source (output valid, char_0, char_1, char_2, char_3, char_count,
		last_of_run, end_of_output, input ready);
	modport sink   (input valid, char_0, char_1, char_2, char_3, char_count,
		last_of_run, end_of_output, output ready);
endinterface

// File: rtl/core/xxe_ram.sv
// generic single write port ram with registered read
module xxe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 45
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem_q[ra];
		end
	end

endmodule

// File: rtl/core/xxe_ctrl.sv
// sequencer of header, line and trailer groups
module xxe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_end,
	output logic             in_ready,
	input  xxe_pkg::xxe_sts_t sts,
	output xxe_pkg::xxe_cmd_t cmd
);
	import xxe_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_HEAD  = 8'b0000_0010,
		ST_LEN   = 8'b0000_0100,
		ST_FETCH = 8'b0000_1000,
		ST_GRP   = 8'b0001_0000,
		ST_NL    = 8'b0010_0000,
		ST_PLUS  = 8'b0100_0000,
		ST_END   = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] head_idx_q, head_idx_d;
	logic [1:0] fetch_k_q, fetch_k_d;
	logic       hdr_done_q, hdr_done_d;
	logic       end_q, end_d;
	logic       go_q, go_d;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		head_idx_d = head_idx_q;
		fetch_k_d  = fetch_k_q;
		hdr_done_d = hdr_done_q;
		end_d      = end_q;
		go_d       = go_q;
		cmd        = '0;
		cmd.sel      = SEL_HEAD;
		cmd.head_idx = head_idx_q;
		cmd.fetch_k  = fetch_k_q;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take   = 1'b1;
					end_d      = in_end;
					go_d       = sts.line_go;
					hdr_done_d = !in_end;
					head_idx_d = 2'd0;
					if (!hdr_done_q) begin
						state_d = ST_HEAD;
					end else if (sts.line_go) begin
						state_d = ST_LEN;
					end else if (in_end) begin
						state_d = ST_PLUS;
					end
				end
			end
			ST_HEAD: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.sel    = SEL_HEAD;
					cmd.last   = (head_idx_q == 2'd2) && !end_q && !go_q;
					head_idx_d = head_idx_q + 2'd1;
					if (head_idx_q == 2'd2) begin
						if (go_q) begin
							state_d = ST_LEN;
						end else if (end_q) begin
							state_d = ST_PLUS;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_LEN: begin
				if (sts.out_free) begin
					cmd.ld_out   = 1'b1;
					cmd.sel      = SEL_LEN;
					cmd.base_clr = 1'b1;
					fetch_k_d    = 2'd0;
					state_d      = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch_en = 1'b1;
				fetch_k_d    = fetch_k_q + 2'd1;
				if (fetch_k_q == 2'd3) begin
					state_d = ST_GRP;
				end
			end
			ST_GRP: begin
				if (sts.out_free) begin
					cmd.ld_out   = 1'b1;
					cmd.sel      = SEL_DATA;
					cmd.base_inc = 1'b1;
					fetch_k_d    = 2'd0;
					state_d      = sts.more_grp ? ST_FETCH : ST_NL;
				end
			end
			ST_NL: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.sel    = SEL_NL;
					cmd.last   = !end_q;
					state_d    = end_q ? ST_PLUS : ST_IDLE;
				end
			end
			ST_PLUS: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.sel    = SEL_PLUS;
					state_d    = ST_END;
				end
			end
			ST_END: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.sel    = SEL_END;
					cmd.last   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_idx_q <= 2'd0;
			fetch_k_q  <= 2'd0;
			hdr_done_q <= 1'b0;
			end_q      <= 1'b0;
			go_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_idx_q <= head_idx_d;
			fetch_k_q  <= fetch_k_d;
			hdr_done_q <= hdr_done_d;
			end_q      <= end_d;
			go_q       <= go_d;
		end
	end

`ifndef SYNTHESIS
	// a group is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> sts.out_free)
		else $error("group loaded while output register busy");

	// closing group ends the stream and rearms the header
	a_end_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && sts.out_free) |=> (state_q == ST_IDLE && !hdr_done_q))
		else $error("stream not closed after end group");

	// three byte reads always lead to a data group
	a_fetch_grp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH && fetch_k_q == 2'd3) |=> (state_q == ST_GRP))
		else $error("fetch did not finish into a data group");
`endif

endmodule

// File: rtl/core/xxe_dp.sv
// datapath: line fill, byte fetch, group build and output register
module xxe_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_data,
	input  logic                  out_ready,
	input  xxe_pkg::xxe_cmd_t     cmd,
	output xxe_pkg::xxe_sts_t     sts,
	output logic                  ram_we,
	output logic [xxe_pkg::ADDR_W-1:0] ram_wa,
	output logic [7:0]            ram_wd,
	output logic                  ram_re,
	output logic [xxe_pkg::ADDR_W-1:0] ram_ra,
	input  logic [7:0]            ram_rd,
	output logic                  out_valid,
	output logic [6:0]            char_0,
	output logic [6:0]            char_1,
	output logic [6:0]            char_2,
	output logic [6:0]            char_3,
	output logic [2:0]            char_count,
	output logic                  last_of_run,
	output logic                  end_of_output
);
	import xxe_pkg::*;

	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  count_q;
	logic [FILL_W-1:0]  base_q;
	logic [FILL_W:0]    rd_pos;
	logic               ok_s1;
	logic [BYTE_W-1:0]  bytes_q [BYTES_PER_GRP];
	logic [23:0]        trip;
	logic               out_valid_q;
	logic [4*CHAR_W-1:0] grp;
	logic [COUNT_W-1:0] grp_n;

	// status toward the controller
	assign sts.line_go  = end_of_data ? (fill_q != '0)
		: (fill_q == FILL_W'(LINE_BYTES - 1));
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.more_grp = ({1'b0, base_q} + (FILL_W+1)'(BYTES_PER_GRP)) < {1'b0, count_q};

	// line store write on a data word
	assign ram_we = cmd.take && !end_of_data;
	assign ram_wa = ADDR_W'(fill_q);
	assign ram_wd = data_byte;

	// byte fetch for one four-character group
	assign rd_pos = {1'b0, base_q} + {{(FILL_W-1){1'b0}}, cmd.fetch_k};
	assign ram_re = cmd.fetch_en && (cmd.fetch_k != 2'd3);
	assign ram_ra = ADDR_W'(rd_pos);

	// fill count and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.take) begin
			if (end_of_data || fill_q == FILL_W'(LINE_BYTES - 1)) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			count_q <= end_of_data ? fill_q : FILL_W'(LINE_BYTES);
		end
		if (cmd.base_clr) begin
			base_q <= '0;
		end else if (cmd.base_inc) begin
			base_q <= base_q + FILL_W'(BYTES_PER_GRP);
		end
		if (ram_re) begin
			ok_s1 <= rd_pos < {1'b0, count_q};
		end
		if (cmd.fetch_en && cmd.fetch_k != 2'd0) begin
			bytes_q[cmd.fetch_k - 2'd1] <= ok_s1 ? ram_rd : '0;
		end
	end

	// group build
	assign trip = {bytes_q[0], bytes_q[1], bytes_q[2]};

	always_comb begin
		grp   = '0;
		grp_n = 3'd1;
		unique case (cmd.sel)
			SEL_HEAD: begin
				grp   = head_grp(cmd.head_idx);
				grp_n = 3'd4;
			end
			SEL_LEN: begin
				grp = {code_of(6'(count_q)), {(3*CHAR_W){1'b0}}};
			end
			SEL_DATA: begin
				grp   = {code_of(trip[23:18]), code_of(trip[17:12]),
					code_of(trip[11:6]), code_of(trip[5:0])};
				grp_n = 3'd4;
			end
			SEL_NL: begin
				grp = {CH_NL, {(3*CHAR_W){1'b0}}};
			end
			SEL_PLUS: begin
				grp   = {CH_PLUS, CH_NL, {(2*CHAR_W){1'b0}}};
				grp_n = 3'd2;
			end
			SEL_END: begin
				grp   = {CH_E, CH_N, CH_D, CH_NL};
				grp_n = 3'd4;
			end
			default: begin
				grp = '0;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			char_0        <= grp[4*CHAR_W-1:3*CHAR_W];
			char_1        <= grp[3*CHAR_W-1:2*CHAR_W];
			char_2        <= grp[2*CHAR_W-1:CHAR_W];
			char_3        <= grp[CHAR_W-1:0];
			char_count    <= grp_n;
			last_of_run   <= cmd.last;
			end_of_output <= (cmd.sel == SEL_END);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/xxencode_stream_encoder_core.sv
// xxencode stream encoder top level: byte words in, character group words out
// a data word that does not complete a line is taken while the sequencer is idle
// a word that causes output moves the sequencer to its header, length or trailer state
// and each group waits for a free output register; line groups come from the single
// read port of the line store (three reads, one capture, then the group load)
// reset clears the sequencer, fill count, header flag and output valid; the
// line store is not cleared; unfilled positions read at a line end give zero bytes
module xxencode_stream_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	xxe_byte_if.sink    byte_stream,
	xxe_text_if.source  text_stream
);
	import xxe_pkg::*;

	xxe_cmd_t          cmd;
	xxe_sts_t          sts;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	logic [7:0]        ram_wd;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_ra;
	logic [7:0]        ram_rd;
	logic              in_ready;

	assign byte_stream.ready = in_ready;

	// sequencer
	xxe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_stream.valid),
		.in_end   (byte_stream.end_of_data),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	xxe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (byte_stream.data_byte),
		.end_of_data   (byte_stream.end_of_data),
		.out_ready     (text_stream.ready),
		.cmd           (cmd),
		.sts           (sts),
		.ram_we        (ram_we),
		.ram_wa        (ram_wa),
		.ram_wd        (ram_wd),
		.ram_re        (ram_re),
		.ram_ra        (ram_ra),
		.ram_rd        (ram_rd),
		.out_valid     (text_stream.valid),
		.char_0        (text_stream.char_0),
		.char_1        (text_stream.char_1),
		.char_2        (text_stream.char_2),
		.char_3        (text_stream.char_3),
		.char_count    (text_stream.char_count),
		.last_of_run   (text_stream.last_of_run),
		.end_of_output (text_stream.end_of_output)
	);

	// line store
	xxe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_BYTES)
	) u_line_ram (
		.clk (clk),
		.we  (ram_we),
		.wa  (ram_wa),
		.wd  (ram_wd),
		.re  (ram_re),
		.ra  (ram_ra),
		.rd  (ram_rd)
	);

endmodule
